FILE: hdl/cvcl_pkg.sv
// Shared constants for the current vector circle limit unit.
// No dependencies.
`timescale 1ns / 1ps
package cvcl_pkg;
	localparam int CURRENT_BITS_DEF = 16;
	localparam int LIMIT_BITS       = 15;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 15'd32767;
	localparam int LIM2_BITS        = 2 * LIMIT_BITS;
	localparam int SCALE_BITS       = 16;
	localparam int QUO_BITS         = 2 * SCALE_BITS;
	localparam int ROOT_REM_BITS    = SCALE_BITS + 1;
endpackage

FILE: hdl/cvcl_div.sv
// Pipelined restoring divider: one quotient bit per stage, remainder starts below divisor.
// Depends on cvcl_pkg.
`timescale 1ns / 1ps
module cvcl_div #(
	parameter int DIV_BITS  = 33,
	parameter int SIDE_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [DIV_BITS-1:0]           in_rem,
	input  logic [DIV_BITS-1:0]           in_div,
	input  logic [SIDE_BITS-1:0]          in_side,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cvcl_pkg::QUO_BITS-1:0] out_quo,
	output logic [SIDE_BITS-1:0]          out_side
);
	localparam int ST = cvcl_pkg::QUO_BITS;

	logic                 v_s    [ST];
	logic [DIV_BITS-1:0]  rem_s  [ST];
	logic [DIV_BITS-1:0]  div_s  [ST];
	logic [ST-1:0]        quo_s  [ST];
	logic [SIDE_BITS-1:0] side_s [ST];
	logic                 en     [ST];
	logic [DIV_BITS-1:0]  rem_n  [ST];
	logic [ST-1:0]        quo_n  [ST];

	always_comb begin
		logic [DIV_BITS:0]   sh;
		logic [DIV_BITS-1:0] r;
		logic [DIV_BITS-1:0] dv;
		logic [ST-1:0]       qo;
		logic                ge;
		for (int k = 0; k < ST; k++) begin
			if (k == 0) begin
				r  = in_rem;
				dv = in_div;
				qo = '0;
			end else begin
				r  = rem_s[k-1];
				dv = div_s[k-1];
				qo = quo_s[k-1];
			end
			sh       = {r, 1'b0};
			ge       = (sh >= {1'b0, dv});
			rem_n[k] = ge ? DIV_BITS'(sh - {1'b0, dv}) : sh[DIV_BITS-1:0];
			quo_n[k] = {qo[ST-2:0], ge};
		end
	end

	always_comb begin
		for (int k = ST - 1; k >= 0; k--) begin
			if (k == ST - 1)
				en[k] = !v_s[k] || out_ready;
			else
				en[k] = !v_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ST; k++)
				v_s[k] <= 1'b0;
		end else begin
			for (int k = 0; k < ST; k++)
				if (en[k])
					v_s[k] <= (k == 0) ? in_valid : v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < ST; k++) begin
			if (en[k]) begin
				rem_s[k]  <= rem_n[k];
				quo_s[k]  <= quo_n[k];
				div_s[k]  <= (k == 0) ? in_div : div_s[k-1];
				side_s[k] <= (k == 0) ? in_side : side_s[k-1];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[ST-1];
	assign out_quo   = quo_s[ST-1];
	assign out_side  = side_s[ST-1];
endmodule

FILE: hdl/cvcl_isqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on cvcl_pkg.
`timescale 1ns / 1ps
module cvcl_isqrt #(
	parameter int SIDE_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [cvcl_pkg::QUO_BITS-1:0]   in_rad,
	input  logic [SIDE_BITS-1:0]            in_side,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [cvcl_pkg::SCALE_BITS-1:0] out_root,
	output logic [SIDE_BITS-1:0]            out_side
);
	localparam int ST = cvcl_pkg::SCALE_BITS;
	localparam int QB = cvcl_pkg::QUO_BITS;
	localparam int RB = cvcl_pkg::ROOT_REM_BITS;

	logic                 v_s    [ST];
	logic [QB-1:0]        rad_s  [ST];
	logic [RB-1:0]        rem_s  [ST];
	logic [ST-1:0]        root_s [ST];
	logic [SIDE_BITS-1:0] side_s [ST];
	logic                 en     [ST];
	logic [RB-1:0]        rem_n  [ST];
	logic [ST-1:0]        root_n [ST];

	always_comb begin
		logic [QB-1:0] rd;
		logic [RB-1:0] r;
		logic [ST-1:0] rt;
		logic [RB+1:0] sh;
		logic [RB+1:0] trial;
		logic          ge;
		for (int k = 0; k < ST; k++) begin
			if (k == 0) begin
				rd = in_rad;
				r  = '0;
				rt = '0;
			end else begin
				rd = rad_s[k-1];
				r  = rem_s[k-1];
				rt = root_s[k-1];
			end
			sh        = {r, rd[QB-1:QB-2]};
			trial     = {{(RB+2-ST-2){1'b0}}, rt, 2'b01};
			ge        = (sh >= trial);
			rem_n[k]  = ge ? RB'(sh - trial) : sh[RB-1:0];
			root_n[k] = {rt[ST-2:0], ge};
		end
	end

	always_comb begin
		for (int k = ST - 1; k >= 0; k--) begin
			if (k == ST - 1)
				en[k] = !v_s[k] || out_ready;
			else
				en[k] = !v_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ST; k++)
				v_s[k] <= 1'b0;
		end else begin
			for (int k = 0; k < ST; k++)
				if (en[k])
					v_s[k] <= (k == 0) ? in_valid : v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < ST; k++) begin
			if (en[k]) begin
				rem_s[k]  <= rem_n[k];
				root_s[k] <= root_n[k];
				rad_s[k]  <= (k == 0) ? {in_rad[QB-3:0], 2'b00} : {rad_s[k-1][QB-3:0], 2'b00};
				side_s[k] <= (k == 0) ? in_side : side_s[k-1];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[ST-1];
	assign out_root  = root_s[ST-1];
	assign out_side  = side_s[ST-1];
endmodule

FILE: hdl/current_vector_circle_limit_unit.sv
// Top level of the d/q current vector circle limit.
// Depends on cvcl_pkg, cvcl_div and cvcl_isqrt.
`timescale 1ns / 1ps
// Usage:
//  Input channel in_valid/in_ready carries one d/q set point pair per word.
//  Output channel out_valid/out_ready returns d_limited, q_limited, was_scaled.
//  Config channel cfg_valid/cfg_ready writes current_limit; always ready.
//  Write it only while no word is in flight.
//  If d^2+q^2 <= limit^2 the pair passes unchanged; otherwise both are
//  multiplied by floor(65536*limit/|v|)/65536, truncated toward zero.
//  Pipeline: 3 front stages, 32 divider stages, 16 square root stages and
//  2 back stages lie between acceptance and out_valid.
//  Throughput: one word per cycle while out_ready is high; every stage
//  has its own valid bit and advances when it is empty or the next stage
//  moves, so bubbles collapse. A stalled receiver holds the output word
//  and backs the pipeline up stage by stage; nothing is dropped or repeated.
//  Reset clears all valid bits and sets current_limit to 32767.
module current_vector_circle_limit_unit #(
	parameter int CURRENT_BITS = cvcl_pkg::CURRENT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cvcl_pkg::LIMIT_BITS-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [CURRENT_BITS-1:0]      d_current,
	input  logic signed [CURRENT_BITS-1:0]      q_current,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [CURRENT_BITS-1:0]      d_limited,
	output logic signed [CURRENT_BITS-1:0]      q_limited,
	output logic                                was_scaled
);
	localparam int CB   = CURRENT_BITS;
	localparam int LB   = cvcl_pkg::LIMIT_BITS;
	localparam int L2B  = cvcl_pkg::LIM2_BITS;
	localparam int SB   = cvcl_pkg::SCALE_BITS;
	localparam int MAGB = 2 * CB + 1;
	localparam int WIDE = (MAGB > L2B) ? MAGB : L2B;

	typedef struct packed {
		logic          scaled;
		logic          dneg;
		logic          qneg;
		logic [CB-1:0] dm;
		logic [CB-1:0] qm;
		logic [CB-1:0] d;
		logic [CB-1:0] q;
	} side_t;

	localparam int SIDEB = $bits(side_t);

	logic [LB-1:0] lim_q;

	logic          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic          en1, en2, en3, en4, en5;
	side_t         side_s1, side_s2, side_s3, side_s4, side_s5;
	side_t         side3_n;
	logic [LB-1:0] lim_s1;
	logic [2*CB-1:0] sqd_s2, sqq_s2;
	logic [L2B-1:0]  lim2_s2, lim2_s3;
	logic [MAGB-1:0] mag2_s3;
	logic [CB+SB-1:0] pd_s4, pq_s4;
	logic [CB-1:0]   d_s5, q_s5;

	logic            div_in_ready, div_out_valid, sq_in_ready, sq_out_valid;
	logic [cvcl_pkg::QUO_BITS-1:0] quo;
	logic [SIDEB-1:0] div_side, sq_side_raw;
	logic [SB-1:0]   root;
	side_t           sq_side;

	logic [CB-1:0] dm_in, qm_in, dmag_out, qmag_out;
	logic [WIDE-1:0] mag2_w, lim2_w;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lim_q <= cvcl_pkg::LIMIT_RESET;
		else if (cfg_valid)
			lim_q <= cfg_data;
	end

	assign dm_in = d_current[CB-1] ? CB'(-d_current) : d_current;
	assign qm_in = q_current[CB-1] ? CB'(-q_current) : q_current;

	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || div_in_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= sq_out_valid;
			if (en5) v_s5 <= v_s4;
		end
	end

	assign mag2_w = WIDE'({1'b0, sqd_s2} + {1'b0, sqq_s2});
	assign lim2_w = WIDE'(lim2_s2);

	always_comb begin
		side3_n        = side_s2;
		side3_n.scaled = (mag2_w > lim2_w);
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			side_s1.scaled <= 1'b0;
			side_s1.dneg   <= d_current[CB-1];
			side_s1.qneg   <= q_current[CB-1];
			side_s1.dm     <= dm_in;
			side_s1.qm     <= qm_in;
			side_s1.d      <= d_current;
			side_s1.q      <= q_current;
			lim_s1         <= lim_q;
		end
		if (en2) begin
			side_s2 <= side_s1;
			sqd_s2  <= side_s1.dm * side_s1.dm;
			sqq_s2  <= side_s1.qm * side_s1.qm;
			lim2_s2 <= lim_s1 * lim_s1;
		end
		if (en3) begin
			side_s3 <= side3_n;
			mag2_s3 <= mag2_w[MAGB-1:0];
			lim2_s3 <= lim2_s2;
		end
		if (en4) begin
			side_s4 <= sq_side;
			pd_s4   <= sq_side.dm * root;
			pq_s4   <= sq_side.qm * root;
		end
		if (en5) begin
			side_s5 <= side_s4;
			if (side_s4.scaled) begin
				d_s5 <= side_s4.dneg ? CB'(-pd_s4[CB+SB-1:SB]) : pd_s4[CB+SB-1:SB];
				q_s5 <= side_s4.qneg ? CB'(-pq_s4[CB+SB-1:SB]) : pq_s4[CB+SB-1:SB];
			end else begin
				d_s5 <= side_s4.d;
				q_s5 <= side_s4.q;
			end
		end
	end

	cvcl_div #(
		.DIV_BITS (MAGB),
		.SIDE_BITS(SIDEB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.in_ready (div_in_ready),
		.in_rem   (MAGB'(lim2_s3)),
		.in_div   (mag2_s3),
		.in_side  (side_s3),
		.out_valid(div_out_valid),
		.out_ready(sq_in_ready),
		.out_quo  (quo),
		.out_side (div_side)
	);

	cvcl_isqrt #(
		.SIDE_BITS(SIDEB)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_out_valid),
		.in_ready (sq_in_ready),
		.in_rad   (quo),
		.in_side  (div_side),
		.out_valid(sq_out_valid),
		.out_ready(en4),
		.out_root (root),
		.out_side (sq_side_raw)
	);

	assign sq_side = side_t'(sq_side_raw);

	assign out_valid  = v_s5;
	assign d_limited  = d_s5;
	assign q_limited  = q_s5;
	assign was_scaled = side_s5.scaled;

	assign dmag_out = d_s5[CB-1] ? CB'(-d_s5) : d_s5;
	assign qmag_out = q_s5[CB-1] ? CB'(-q_s5) : q_s5;

`ifndef SYNTH
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted word missing from first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en1 |=> v_s1 && $stable(side_s1))
		else $error("stalled first stage lost its word");

	a_scaled_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_scaled |-> (d_s5 == '0 || d_s5[CB-1] == side_s5.dneg) &&
			(q_s5 == '0 || q_s5[CB-1] == side_s5.qneg))
		else $error("scaled output changed sign");

	a_scaled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_scaled |-> (dmag_out <= side_s5.dm) && (qmag_out <= side_s5.qm))
		else $error("scaled output grew");
`endif
endmodule
